// ===== design/gpsp_pkg.sv =====
package gpsp_pkg;

  // Field and register widths
  localparam int ROW_W     = 10;
  localparam int HEIGHT_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int CENTER_W  = 18;
  localparam int ZC_W      = 24;
  localparam int BIAS_W    = 19;
  localparam int PAD_W     = 20;
  localparam int SCALE_W   = 18;
  localparam int OUT_W     = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // Squared length is held in 64 bits, its root in 32
  localparam int RAD_W = 64;

  // Parameter defaults
  localparam int GRID_DIM_DEF  = 1024;
  localparam int FRAC_BITS_DEF = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_CENTER       = 3'd0,
    REG_Y_CENTER       = 3'd1,
    REG_Z_CENTER       = 3'd2,
    REG_HEIGHT_GAIN    = 3'd3,
    REG_BIAS           = 3'd4,
    REG_PAD_HORIZONTAL = 3'd5,
    REG_PAD_VERTICAL   = 3'd6,
    REG_SCREEN_SCALE   = 3'd7
  } reg_idx_t;

  // Per-point data that rides along the divider
  typedef struct packed {
    logic                       neg_x;
    logic                       neg_y;
    logic signed [HEIGHT_W-1:0] height;
  } gpsp_side_t;

endpackage

// ===== design/grid_point_sphere_projection.sv =====
// Channel  Direction  Beat contents
// in       sink       row, column, height
// out      source     screen_x, screen_y, height_out
// cfg      sink       cfg_index, cfg_data (always ready)
//
// One point enters per clock unless a waiting result on out freezes the pipeline;
// the path runs through the 32-stage square root and the NUM_W-stage divider.
// rst is synchronous, clears the valid bits and resets the configuration registers to their defaults.
// A waiting result on out freezes the whole pipeline; in_ready drops in the same cycle.
module grid_point_sphere_projection #(
  parameter int GRID_DIM  = gpsp_pkg::GRID_DIM_DEF,
  parameter int FRAC_BITS = gpsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [gpsp_pkg::ROW_W-1:0]           row,
  input  logic [gpsp_pkg::ROW_W-1:0]           column,
  input  logic signed [gpsp_pkg::HEIGHT_W-1:0] height,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [gpsp_pkg::OUT_W-1:0]    screen_x,
  output logic signed [gpsp_pkg::OUT_W-1:0]    screen_y,
  output logic signed [gpsp_pkg::HEIGHT_W-1:0] height_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gpsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gpsp_pkg::CFG_W-1:0]           cfg_data
);

  import gpsp_pkg::*;

  localparam int SHIFT_W = ROW_W + FRAC_BITS;
  localparam int BXY_W   = ((SHIFT_W > BIAS_W) ? SHIFT_W : BIAS_W) + 2;
  localparam int MAG_W   = BXY_W - 1;
  localparam int PROD_W  = HEIGHT_W + GAIN_W;
  localparam int BZ_W    = PROD_W + 1;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int NUM_W   = MAG_W + SCALE_W;
  localparam int R_W     = NUM_W + 2;
  localparam int SIDE_W  = 2 * MAG_W + 2 + HEIGHT_W;
  localparam int CMP_W   = 17;

  localparam logic [ROOT_W-1:0]     D_ONE    = ROOT_W'(1) << FRAC_BITS;
  localparam logic [ROOT_W-1:0]     ROOT_MAX = 32'hB504F333;
  localparam logic signed [R_W-1:0] SAT_HI   = R_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [R_W-1:0] SAT_LO   = R_W'(-(1 << (OUT_W - 1)));
  localparam logic [ROW_W-1:0]      IDX_LIM  = ROW_W'(GRID_DIM - 1);

  logic en;

  // Configuration registers
  logic [CENTER_W-1:0]      x_center, y_center;
  logic signed [ZC_W-1:0]   z_center;
  logic signed [GAIN_W-1:0] height_gain;
  logic signed [BIAS_W-1:0] bias;
  logic [PAD_W-1:0]         pad_horizontal, pad_vertical;
  logic [SCALE_W-1:0]       screen_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_center       <= '0;
      y_center       <= '0;
      z_center       <= '0;
      height_gain    <= GAIN_W'(1 << FRAC_BITS);
      bias           <= '0;
      pad_horizontal <= '0;
      pad_vertical   <= '0;
      screen_scale   <= SCALE_W'(1 << FRAC_BITS);
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_X_CENTER:       x_center       <= cfg_data[CENTER_W-1:0];
        REG_Y_CENTER:       y_center       <= cfg_data[CENTER_W-1:0];
        REG_Z_CENTER:       z_center       <= signed'(cfg_data[ZC_W-1:0]);
        REG_HEIGHT_GAIN:    height_gain    <= signed'(cfg_data[GAIN_W-1:0]);
        REG_BIAS:           bias           <= signed'(cfg_data[BIAS_W-1:0]);
        REG_PAD_HORIZONTAL: pad_horizontal <= cfg_data[PAD_W-1:0];
        REG_PAD_VERTICAL:   pad_vertical   <= cfg_data[PAD_W-1:0];
        REG_SCREEN_SCALE:   screen_scale   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless the output holds an untaken beat
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: clamp indexes, center and bias x and y, height times gain
  logic [ROW_W-1:0]          row_c, col_c;
  logic signed [BXY_W-1:0]   col_s, row_s, xc_s, yc_s, bias_s;
  logic                      v1;
  logic signed [BXY_W-1:0]   s1_bx, s1_by;
  logic signed [PROD_W-1:0]  s1_prod;
  logic signed [HEIGHT_W-1:0] s1_h;

  assign row_c  = (CMP_W'(row) >= CMP_W'(GRID_DIM)) ? IDX_LIM : row;
  assign col_c  = (CMP_W'(column) >= CMP_W'(GRID_DIM)) ? IDX_LIM : column;
  assign col_s  = signed'(BXY_W'({col_c, {FRAC_BITS{1'b0}}}));
  assign row_s  = signed'(BXY_W'({row_c, {FRAC_BITS{1'b0}}}));
  assign xc_s   = signed'(BXY_W'(x_center));
  assign yc_s   = signed'(BXY_W'(y_center));
  assign bias_s = BXY_W'(bias);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bx   <= col_s - xc_s + bias_s;
      s1_by   <= row_s - yc_s + bias_s;
      s1_prod <= height * height_gain;
      s1_h    <= height;
    end
  end

  // Stage 2: center and bias z
  logic                       v2;
  logic signed [BXY_W-1:0]    s2_bx, s2_by;
  logic signed [BZ_W-1:0]     s2_bz;
  logic signed [HEIGHT_W-1:0] s2_h;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bx <= s1_bx;
      s2_by <= s1_by;
      s2_bz <= BZ_W'(s1_prod) - BZ_W'(z_center) + BZ_W'(bias);
      s2_h  <= s1_h;
    end
  end

  // Stage 3: magnitudes and signs
  logic                       v3;
  logic [MAG_W-1:0]           s3_mx, s3_my;
  logic [PROD_W-1:0]          s3_mz;
  logic                       s3_nx, s3_ny;
  logic signed [HEIGHT_W-1:0] s3_h;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mx <= MAG_W'(s2_bx < 0 ? -s2_bx : s2_bx);
      s3_my <= MAG_W'(s2_by < 0 ? -s2_by : s2_by);
      s3_mz <= PROD_W'(s2_bz < 0 ? -s2_bz : s2_bz);
      s3_nx <= s2_bx < 0;
      s3_ny <= s2_by < 0;
      s3_h  <= s2_h;
    end
  end

  // Stage 4: squares
  logic                       v4;
  logic [2*MAG_W-1:0]         s4_sqx, s4_sqy;
  logic [RAD_W-1:0]           s4_sqz;
  logic [MAG_W-1:0]           s4_mx, s4_my;
  logic                       s4_nx, s4_ny;
  logic signed [HEIGHT_W-1:0] s4_h;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sqx <= s3_mx * s3_mx;
      s4_sqy <= s3_my * s3_my;
      s4_sqz <= s3_mz * s3_mz;
      s4_mx  <= s3_mx;
      s4_my  <= s3_my;
      s4_nx  <= s3_nx;
      s4_ny  <= s3_ny;
      s4_h   <= s3_h;
    end
  end

  // Stage 5: squared length
  logic                       v5;
  logic [RAD_W-1:0]           s5_sum;
  logic [MAG_W-1:0]           s5_mx, s5_my;
  logic                       s5_nx, s5_ny;
  logic signed [HEIGHT_W-1:0] s5_h;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sum <= RAD_W'(s4_sqx) + RAD_W'(s4_sqy) + s4_sqz;
      s5_mx  <= s4_mx;
      s5_my  <= s4_my;
      s5_nx  <= s4_nx;
      s5_ny  <= s4_ny;
      s5_h   <= s4_h;
    end
  end

  // Front-end valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Length by pipelined square root
  logic                       sq_v;
  logic [ROOT_W-1:0]          sq_root;
  logic [SIDE_W-1:0]          sq_side_in, sq_side;
  logic [MAG_W-1:0]           sq_mx, sq_my;
  logic                       sq_nx, sq_ny;
  logic signed [HEIGHT_W-1:0] sq_h;

  assign sq_side_in = {s5_mx, s5_my, s5_nx, s5_ny, s5_h};

  gpsp_sqrt #(
    .RAD_W  (RAD_W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .radicand  (s5_sum),
    .side_in   (sq_side_in),
    .out_valid (sq_v),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  assign {sq_mx, sq_my, sq_nx, sq_ny, sq_h} = sq_side;

  // Stage 6: zero-length fixup and scaled numerators
  logic              s6_v;
  logic [ROOT_W-1:0] s6_d;
  logic [NUM_W-1:0]  s6_numx, s6_numy;
  gpsp_side_t        s6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_d           <= (sq_root == '0) ? D_ONE : sq_root;
      s6_numx        <= sq_mx * screen_scale;
      s6_numy        <= sq_my * screen_scale;
      s6_side.neg_x  <= sq_nx;
      s6_side.neg_y  <= sq_ny;
      s6_side.height <= sq_h;
    end
  end

  // Quotients by pipelined divider
  logic             dv_v;
  logic [NUM_W-1:0] dv_qx, dv_qy;
  gpsp_side_t       dv_side;

  gpsp_div #(
    .NUM_W (NUM_W),
    .DEN_W (ROOT_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_v),
    .num_x     (s6_numx),
    .num_y     (s6_numy),
    .den       (s6_d),
    .side_in   (s6_side),
    .out_valid (dv_v),
    .quo_x     (dv_qx),
    .quo_y     (dv_qy),
    .side_out  (dv_side)
  );

  // Output stage: restore sign, add pad, saturate
  logic signed [R_W-1:0] qsx, qsy, rx, ry;
  logic signed [OUT_W-1:0] sat_x, sat_y;

  assign qsx = dv_side.neg_x ? -signed'(R_W'(dv_qx)) : signed'(R_W'(dv_qx));
  assign qsy = dv_side.neg_y ? -signed'(R_W'(dv_qy)) : signed'(R_W'(dv_qy));
  assign rx  = qsx + signed'(R_W'(pad_horizontal));
  assign ry  = qsy + signed'(R_W'(pad_vertical));

  assign sat_x = (rx > SAT_HI) ? OUT_W'(SAT_HI) : (rx < SAT_LO) ? OUT_W'(SAT_LO) : OUT_W'(rx);
  assign sat_y = (ry > SAT_HI) ? OUT_W'(SAT_HI) : (ry < SAT_LO) ? OUT_W'(SAT_LO) : OUT_W'(ry);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      screen_x   <= sat_x;
      screen_y   <= sat_y;
      height_out <= dv_side.height;
    end
  end

  // Checks
  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid right after reset");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst) s6_v |-> s6_d != '0)
    else $error("divider fed a zero length");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    sq_v |-> sq_root <= ROOT_MAX)
    else $error("square root exceeds range of squared length");

endmodule

// ===== design/gpsp_sqrt.sv =====
module gpsp_sqrt #(
  parameter int RAD_W  = 64,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [RAD_W-1:0]      radicand,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic [RAD_W/2-1:0]    root,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int ROOT_W = RAD_W / 2;

  // One result bit per stage, most significant first
  logic [RAD_W-1:0]  rem  [1:ROOT_W];
  logic [ROOT_W-1:0] rt   [1:ROOT_W];
  logic [SIDE_W-1:0] side [1:ROOT_W];
  logic              vld  [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int BIT = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  rem_in;
    logic [RAD_W-1:0]  trial;
    logic [ROOT_W-1:0] rt_in;
    logic [SIDE_W-1:0] side_k;
    logic              v_in;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = radicand;
      assign rt_in  = '0;
      assign side_k = side_in;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem[k];
      assign rt_in  = rt[k];
      assign side_k = side[k];
      assign v_in   = vld[k];
    end

    // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
    assign trial = (RAD_W'(rt_in) << (BIT + 1)) | (RAD_W'(1) << (2 * BIT));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? rem_in - trial : rem_in;
        rt[k+1]   <= take ? (rt_in | (ROOT_W'(1) << BIT)) : rt_in;
        side[k+1] <= side_k;
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign side_out  = side[ROOT_W];

endmodule

// ===== design/gpsp_div.sv =====
module gpsp_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [NUM_W-1:0]             num_x,
  input  logic [NUM_W-1:0]             num_y,
  input  logic [DEN_W-1:0]             den,
  input  gpsp_pkg::gpsp_side_t         side_in,
  output logic                         out_valid,
  output logic [NUM_W-1:0]             quo_x,
  output logic [NUM_W-1:0]             quo_y,
  output gpsp_pkg::gpsp_side_t         side_out
);

  import gpsp_pkg::*;

  // Restoring division, one quotient bit per stage for both lanes
  logic [NUM_W-1:0] nx   [1:NUM_W];
  logic [NUM_W-1:0] ny   [1:NUM_W];
  logic [NUM_W-1:0] qx   [1:NUM_W];
  logic [NUM_W-1:0] qy   [1:NUM_W];
  logic [DEN_W-1:0] rx   [1:NUM_W];
  logic [DEN_W-1:0] ry   [1:NUM_W];
  logic [DEN_W-1:0] dd   [1:NUM_W];
  gpsp_side_t       side [1:NUM_W];
  logic             vld  [1:NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    localparam int BIT = NUM_W - 1 - k;
    logic [NUM_W-1:0] nx_in, ny_in, qx_in, qy_in;
    logic [DEN_W-1:0] rx_in, ry_in, d_in;
    logic [DEN_W:0]   shx, shy;
    logic             gex, gey;
    gpsp_side_t       side_k;
    logic             v_in;

    if (k == 0) begin : g_first
      assign nx_in  = num_x;
      assign ny_in  = num_y;
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign rx_in  = '0;
      assign ry_in  = '0;
      assign d_in   = den;
      assign side_k = side_in;
      assign v_in   = in_valid;
    end else begin : g_next
      assign nx_in  = nx[k];
      assign ny_in  = ny[k];
      assign qx_in  = qx[k];
      assign qy_in  = qy[k];
      assign rx_in  = rx[k];
      assign ry_in  = ry[k];
      assign d_in   = dd[k];
      assign side_k = side[k];
      assign v_in   = vld[k];
    end

    // Bring down the next numerator bit and try the subtract
    assign shx = {rx_in, nx_in[BIT]};
    assign shy = {ry_in, ny_in[BIT]};
    assign gex = shx >= {1'b0, d_in};
    assign gey = shy >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx[k+1]   <= nx_in;
        ny[k+1]   <= ny_in;
        qx[k+1]   <= gex ? (qx_in | (NUM_W'(1) << BIT)) : qx_in;
        qy[k+1]   <= gey ? (qy_in | (NUM_W'(1) << BIT)) : qy_in;
        rx[k+1]   <= gex ? DEN_W'(shx - {1'b0, d_in}) : shx[DEN_W-1:0];
        ry[k+1]   <= gey ? DEN_W'(shy - {1'b0, d_in}) : shy[DEN_W-1:0];
        dd[k+1]   <= d_in;
        side[k+1] <= side_k;
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo_x     = qx[NUM_W];
  assign quo_y     = qy[NUM_W];
  assign side_out  = side[NUM_W];

endmodule
